// ----- hdl/mss_pkg.sv -----
// ----------------------------------------------------------------------------
// mss_pkg: shared types and constants for the motion step sequencer
// Beat structs, codes, and the sign helper used by the back.
// ----------------------------------------------------------------------------
package mss_pkg;

	localparam int MaxSteps   = 8;
	localparam int SlotW      = 4;
	localparam int Depth      = MaxSteps + 1;
	localparam logic [15:0] AngleFull = 16'd36000;
	localparam logic [15:0] AngleHalf = 16'd18000;

	typedef enum logic [2:0] {
		CMD_TICK   = 3'd0,
		CMD_START  = 3'd1,
		CMD_STOP   = 3'd2,
		CMD_LOAD   = 3'd3,
		CMD_RESUME = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		REQ_NONE     = 2'd0,
		REQ_START    = 2'd1,
		REQ_RETARGET = 2'd2,
		REQ_CANCEL   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		PH_STOPPED  = 2'd0,
		PH_MOVING   = 2'd1,
		PH_DWELLING = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		SGN_ZERO = 2'd0,
		SGN_POS  = 2'd1,
		SGN_NEG  = 2'd3
	} sign_t;

	localparam logic [1:0] DirCw  = 2'd1;
	localparam logic [1:0] DirCcw = 2'd2;
	localparam logic [1:0] DirBad = 2'd3;
	localparam logic [1:0] DirShort = 2'd0;

	typedef struct packed {
		logic [2:0]  command;
		logic [31:0] now_ms;
		logic [31:0] pause_ms;
		logic [3:0]  step_slot;
		logic [15:0] step_target;
		logic [15:0] step_speed;
		logic [1:0]  step_direction;
		logic [31:0] step_dwell;
		logic        move_active;
		logic        near_target;
		logic        retarget_ok;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]  move_request;
		logic [15:0] move_target;
		logic [15:0] move_speed;
		logic [1:0]  move_direction;
		logic [1:0]  phase;
		logic [3:0]  active_step;
		logic        is_running;
	} out_beat_t;

	// Classified item handed from front to back
	typedef struct packed {
		cmd_t        cmd;
		logic        load_ok;
		logic [31:0] now_ms;
		logic [31:0] pause_ms;
		logic [3:0]  slot;
		logic [15:0] target;
		logic [15:0] speed;
		logic [1:0]  dir;
		logic [31:0] dwell;
		logic        active;
		logic        near;
		logic        ok;
	} work_t;

	// Direction sign from a step's mode or the wrapped angle difference.
	function automatic sign_t sign_of(logic [1:0] dir_to, logic [15:0] tgt_from,
			logic [15:0] tgt_to);
		logic [16:0] d;
		sign_t s;
		d = {1'b0, tgt_to} + {1'b0, AngleFull} - {1'b0, tgt_from};
		if (d >= {1'b0, AngleFull})
			d = d - {1'b0, AngleFull};
		if (dir_to == DirCw)
			s = SGN_POS;
		else if (dir_to == DirCcw)
			s = SGN_NEG;
		else if (d == 17'd0)
			s = SGN_ZERO;
		else if (d < {1'b0, AngleHalf})
			s = SGN_POS;
		else
			s = SGN_NEG;
		return s;
	endfunction

endpackage

// ----- hdl/mss_front.sv -----
// ----------------------------------------------------------------------------
// mss_front: input stage
// Accepts beats, decodes the command and normalizes load data.
// ----------------------------------------------------------------------------
module mss_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid,
	output logic              ready,
	input  mss_pkg::in_beat_t data,
	output logic              wvalid,
	input  logic              wready,
	output mss_pkg::work_t    wdata
);

	logic             vld_q;
	mss_pkg::work_t   w_q;
	mss_pkg::work_t   w_d;
	logic [16:0]      tred;

	assign ready  = !vld_q || wready;
	assign wvalid = vld_q;
	assign wdata  = w_q;

	always_comb begin
		tred = {1'b0, data.step_target};
		if (tred >= {1'b0, mss_pkg::AngleFull})
			tred = tred - {1'b0, mss_pkg::AngleFull};
		w_d.cmd      = mss_pkg::cmd_t'(data.command);
		w_d.load_ok  = (data.step_slot <= mss_pkg::SlotW'(mss_pkg::MaxSteps));
		w_d.now_ms   = data.now_ms;
		w_d.pause_ms = data.pause_ms;
		w_d.slot     = data.step_slot;
		w_d.target   = tred[15:0];
		w_d.speed    = data.step_speed;
		w_d.dir      = (data.step_direction == mss_pkg::DirBad) ? mss_pkg::DirShort
			: data.step_direction;
		w_d.dwell    = data.step_dwell;
		w_d.active   = data.move_active;
		w_d.near     = data.near_target;
		w_d.ok       = data.retarget_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= 1'b0;
		else if (ready)
			vld_q <= valid;
	end

	always_ff @(posedge clk) begin
		if (valid && ready)
			w_q <= w_d;
	end

endmodule

// ----- hdl/mss_back.sv -----
// ----------------------------------------------------------------------------
// mss_back: sequencer core
// Holds step tables and phase state; runs one item per cycle while oready keeps the result register free.
// ----------------------------------------------------------------------------
module mss_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wvalid,
	output logic               wready,
	input  mss_pkg::work_t     wdata,
	input  logic [3:0]         loop_len,
	output logic               ovalid,
	input  logic               oready,
	output mss_pkg::out_beat_t odata
);

	localparam int D = mss_pkg::Depth;

	logic [15:0] tgt_q [D];
	logic [15:0] spd_q [D];
	logic [1:0]  dir_q [D];
	logic [31:0] dwl_q [D];

	logic              run_q;
	mss_pkg::phase_t   ph_q;
	logic [3:0]        cur_q;
	logic [3:0]        nxt_q;
	mss_pkg::sign_t    sgn_q;
	logic [31:0]       pst_q;
	logic              ov_q;
	mss_pkg::out_beat_t o_q;

	logic              run_d;
	mss_pkg::phase_t   ph_d;
	logic [3:0]        cur_d, nxt_d, nxt_adv, cur_s, nxt_s, req_s;
	mss_pkg::sign_t    sgn_d, ns;
	logic [31:0]       pst_d;
	mss_pkg::req_t     req;
	logic              issue;
	logic              fire;
	logic              done;

	assign wready = !ov_q || oready;
	assign fire   = wvalid && wready;
	assign ovalid = ov_q;
	assign odata  = o_q;

	// out of range index reads slot zero
	assign cur_s = (cur_q <= 4'(mss_pkg::MaxSteps)) ? cur_q : 4'd0;
	assign nxt_s = (nxt_q <= 4'(mss_pkg::MaxSteps)) ? nxt_q : 4'd0;
	assign ns = mss_pkg::sign_of(dir_q[nxt_s], tgt_q[cur_s], tgt_q[nxt_s]);
	assign nxt_adv = (nxt_q + 4'd1 > loop_len) ? 4'd1 : nxt_q + 4'd1;

	always_comb begin
		run_d = run_q; ph_d = ph_q; cur_d = cur_q; nxt_d = nxt_q;
		sgn_d = sgn_q; pst_d = pst_q;
		req = mss_pkg::REQ_NONE; issue = 1'b0; req_s = 4'd0; done = 1'b0;
		unique case (wdata.cmd)
			mss_pkg::CMD_TICK: begin
				if (run_q) begin
					if (ph_q == mss_pkg::PH_MOVING && cur_q != 4'd0 && dwl_q[cur_s] == 32'd0
							&& wdata.near
							&& !(sgn_q != mss_pkg::SGN_ZERO && ns != mss_pkg::SGN_ZERO
								&& sgn_q != ns)) begin
						req = mss_pkg::REQ_RETARGET; issue = 1'b1; req_s = nxt_s;
						if (wdata.ok) begin
							cur_d = nxt_q; sgn_d = ns; nxt_d = nxt_adv; done = 1'b1;
						end
					end
					if (!done) begin
						if (ph_q == mss_pkg::PH_MOVING && !wdata.active) begin
							ph_d = mss_pkg::PH_DWELLING; pst_d = wdata.now_ms;
						end else if (ph_q == mss_pkg::PH_DWELLING
								&& (wdata.now_ms - pst_q) >= dwl_q[cur_s]) begin
							cur_d = nxt_q; ph_d = mss_pkg::PH_MOVING; sgn_d = ns;
							req = mss_pkg::REQ_START; issue = 1'b1; req_s = nxt_s;
							nxt_d = nxt_adv;
						end
					end
				end
			end
			mss_pkg::CMD_START: begin
				if (!run_q) begin
					run_d = 1'b1; pst_d = wdata.now_ms; nxt_d = 4'd1;
					sgn_d = mss_pkg::SGN_ZERO; cur_d = 4'd0; ph_d = mss_pkg::PH_MOVING;
					req = mss_pkg::REQ_START; issue = 1'b1; req_s = 4'd0;
				end
			end
			mss_pkg::CMD_STOP: begin
				run_d = 1'b0; ph_d = mss_pkg::PH_STOPPED; cur_d = 4'd0; nxt_d = 4'd1;
				sgn_d = mss_pkg::SGN_ZERO; req = mss_pkg::REQ_CANCEL;
			end
			mss_pkg::CMD_RESUME: begin
				if (run_q) pst_d = pst_q + wdata.pause_ms;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < D; i++) begin
				tgt_q[i] <= '0; spd_q[i] <= '0; dir_q[i] <= '0; dwl_q[i] <= '0;
			end
			run_q <= 1'b0; ph_q <= mss_pkg::PH_STOPPED; cur_q <= 4'd0; nxt_q <= 4'd1;
			sgn_q <= mss_pkg::SGN_ZERO; pst_q <= '0; ov_q <= 1'b0;
		end else begin
			if (wready) ov_q <= wvalid;
			if (fire) begin
				run_q <= run_d; ph_q <= ph_d; cur_q <= cur_d; nxt_q <= nxt_d;
				sgn_q <= sgn_d; pst_q <= pst_d;
				if (wdata.cmd == mss_pkg::CMD_LOAD && wdata.load_ok) begin
					tgt_q[wdata.slot] <= wdata.target;
					spd_q[wdata.slot] <= wdata.speed;
					dir_q[wdata.slot] <= wdata.dir;
					dwl_q[wdata.slot] <= wdata.dwell;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			o_q.move_request   <= req;
			o_q.move_target    <= issue ? tgt_q[req_s] : 16'd0;
			o_q.move_speed     <= issue ? spd_q[req_s] : 16'd0;
			o_q.move_direction <= issue ? dir_q[req_s] : 2'd0;
			o_q.phase          <= ph_d;
			o_q.active_step    <= cur_d;
			o_q.is_running     <= run_d;
		end
	end

endmodule

// ----- hdl/motion_step_sequencer.sv -----
// ----------------------------------------------------------------------------
// motion_step_sequencer: step table sequencer for a motor executor
// Startup step, then a looping list of steps with dwell and blending.
// ----------------------------------------------------------------------------
// Usage:
//  - in channel (in_valid/in_ready/in_data): one beat per command: tick,
//    start, stop, load step or resume, with the executor's status bits.
//  - out channel (out_valid/out_ready/out_data): exactly one beat per input
//    beat, carrying the move request and the sequencer status after it.
//  - APB port: register 0 at address 0 is the loop length, clamped to 1..8
//    on write; reads return the held value.
// An accepted in beat passes the front decode register and then the
// sequencer core, whose result register holds the out beat. Throughput is
// one beat per cycle while out_ready is high; the whole step update is
// combinational logic in the core, ahead of its result register.
// Reset clears all step tables, stops the sequence and sets the loop length
// to 1. When out_ready is low the result register holds; the front register
// then fills and in_ready drops, so nothing is lost. Writes to the loop
// length are expected only while no beat is in flight.
// ----------------------------------------------------------------------------
module motion_step_sequencer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  mss_pkg::in_beat_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output mss_pkg::out_beat_t out_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [1:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic           wvalid, wready;
	mss_pkg::work_t wdata;
	logic [3:0]     cnt_q;
	logic [3:0]     wv;

	assign pready = 1'b1;
	assign wv = pwdata[3:0];
	assign prdata = (paddr == 2'd0) ? {28'd0, cnt_q} : 32'd0;

	// loop length register with clamping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= 4'd1;
		else if (psel && penable && pwrite && paddr == 2'd0) begin
			if (wv == 4'd0)
				cnt_q <= 4'd1;
			else if (wv > 4'(mss_pkg::MaxSteps))
				cnt_q <= 4'(mss_pkg::MaxSteps);
			else
				cnt_q <= wv;
		end
	end

	mss_front u_front (
		.clk(clk), .arst_n(arst_n),
		.valid(in_valid), .ready(in_ready), .data(in_data),
		.wvalid(wvalid), .wready(wready), .wdata(wdata)
	);

	mss_back u_back (
		.clk(clk), .arst_n(arst_n),
		.wvalid(wvalid), .wready(wready), .wdata(wdata),
		.loop_len(cnt_q),
		.ovalid(out_valid), .oready(out_ready), .odata(out_data)
	);

endmodule

// ----- test/mss_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_checker: sequencer behavior predictor and result comparator
// Watches both beat channels and the register port, keeps its own copy of
// the step tables and sequencer state, and compares every out beat in order.
// ----------------------------------------------------------------------------
module mss_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  mss_pkg::in_beat_t  in_data,
	input  logic               out_valid,
	input  logic               out_ready,
	input  mss_pkg::out_beat_t out_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [1:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	output int                 fail_count,
	output int                 pending_count
);
	import mss_pkg::*;

	logic [15:0] tgt_tab [Depth];
	logic [15:0] spd_tab [Depth];
	logic [1:0]  dir_tab [Depth];
	logic [31:0] dwl_tab [Depth];
	logic [3:0]  steps_used;
	logic        running;
	phase_t      ph;
	logic [3:0]  cur_idx;
	logic [3:0]  nxt_idx;
	int          heading;
	logic [31:0] ph_start;
	out_beat_t   expected_beats[$];

	assign pending_count = expected_beats.size();

	function automatic int slot_fix(logic [3:0] i);
		return (i <= MaxSteps) ? int'(i) : 0;
	endfunction

	function automatic int heading_between(logic [3:0] a, logic [3:0] b);
		int f, t;
		int d;
		f = slot_fix(a);
		t = slot_fix(b);
		if (dir_tab[t] == DirCw) return 1;
		if (dir_tab[t] == DirCcw) return -1;
		d = (int'(tgt_tab[t]) + 36000 - int'(tgt_tab[f])) % 36000;
		if (d == 0) return 0;
		return (d < 18000) ? 1 : -1;
	endfunction

	function automatic void request(ref out_beat_t r, input req_t k, input logic [3:0] s);
		int i;
		i = slot_fix(s);
		r.move_request = k;
		r.move_target = tgt_tab[i];
		r.move_speed = spd_tab[i];
		r.move_direction = dir_tab[i];
	endfunction

	function automatic void bump_next();
		nxt_idx = nxt_idx + 4'd1;
		if (nxt_idx > steps_used) nxt_idx = 4'd1;
	endfunction

	// tick: blend check, move end, dwell expiry
	function automatic void tick_update(ref out_beat_t r, input in_beat_t b);
		int ns;
		logic rev;
		logic [3:0] from;
		if (!running) return;
		if (ph == PH_MOVING && cur_idx != 0 && dwl_tab[slot_fix(cur_idx)] == 0) begin
			ns = heading_between(cur_idx, nxt_idx);
			rev = heading != 0 && ns != 0 && heading != ns;
			if (!rev && b.near_target) begin
				request(r, REQ_RETARGET, nxt_idx);
				if (b.retarget_ok) begin
					cur_idx = nxt_idx;
					heading = ns;
					bump_next();
					return;
				end
			end
		end
		if (ph == PH_MOVING && !b.move_active) begin
			ph = PH_DWELLING;
			ph_start = b.now_ms;
			return;
		end
		if (ph != PH_DWELLING) return;
		if (b.now_ms - ph_start < dwl_tab[slot_fix(cur_idx)]) return;
		from = cur_idx;
		cur_idx = nxt_idx;
		ph = PH_MOVING;
		heading = heading_between(from, cur_idx);
		request(r, REQ_START, cur_idx);
		bump_next();
	endfunction

	function automatic out_beat_t predict_beat(in_beat_t b);
		out_beat_t r;
		r = '0;
		case (b.command)
			CMD_TICK: tick_update(r, b);
			CMD_START: begin
				if (!running) begin
					running = 1'b1;
					ph_start = b.now_ms;
					nxt_idx = 4'd1;
					cur_idx = 4'd0;
					ph = PH_MOVING;
					heading = 0;
					request(r, REQ_START, 4'd0);
				end
			end
			CMD_STOP: begin
				running = 1'b0;
				ph = PH_STOPPED;
				cur_idx = 4'd0;
				nxt_idx = 4'd1;
				heading = 0;
				r.move_request = REQ_CANCEL;
			end
			CMD_LOAD: begin
				if (b.step_slot <= MaxSteps) begin
					tgt_tab[b.step_slot] = 16'(32'(b.step_target) % 36000);
					spd_tab[b.step_slot] = b.step_speed;
					dir_tab[b.step_slot] = (b.step_direction == DirBad) ? DirShort
						: b.step_direction;
					dwl_tab[b.step_slot] = b.step_dwell;
				end
			end
			CMD_RESUME: if (running) ph_start = ph_start + b.pause_ms;
			default: ;
		endcase
		r.phase = ph;
		r.active_step = cur_idx;
		r.is_running = running;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_beat_t e;
		logic [3:0] v;
		if (!arst_n) begin
			for (int i = 0; i < Depth; i++) begin
				tgt_tab[i] = '0;
				spd_tab[i] = '0;
				dir_tab[i] = '0;
				dwl_tab[i] = '0;
			end
			steps_used = 4'd1;
			running = 1'b0;
			ph = PH_STOPPED;
			cur_idx = '0;
			nxt_idx = 4'd1;
			heading = 0;
			ph_start = '0;
			expected_beats.delete();
			fail_count = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == 2'd0) begin
				v = pwdata[3:0];
				if (v < 1) v = 4'd1;
				if (v > MaxSteps) v = 4'(MaxSteps);
				steps_used = v;
			end
			if (out_valid && out_ready) begin
				if (expected_beats.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected out beat %p", out_data);
				end else begin
					e = expected_beats.pop_front();
					if (out_data !== e) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected %p got %p", e, out_data);
					end
				end
			end
			if (in_valid && in_ready)
				expected_beats.push_back(predict_beat(in_data));
		end
	end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: motion step sequencer stimulus and verdict
// Directed command cases, then random runs of loads, start, ticks, resumes
// and stops, some malformed, random handshake gaps and a long receiver stall.
// ----------------------------------------------------------------------------
module testbench;
	import mss_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	in_beat_t   in_data = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	out_beat_t  out_data;
	logic       psel = 1'b0;
	logic       penable = 1'b0;
	logic       pwrite = 1'b0;
	logic [1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic       pready;
	int         fail_count;
	int         pending_count;
	int         stall_len = 0;  // set by stimulus to force one long hold-off
	logic [31:0] clock_ms = '0; // running millisecond time for ticks

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	motion_step_sequencer i_dut (.*);

	mss_checker i_checker (.*);

	// receiver: a random wait before each beat, or one long stall on request
	initial begin
		int w;
		@(posedge arst_n);
		forever begin
			if (stall_len > 0) begin
				w = stall_len;
				stall_len = 0;
			end else
				w = $urandom_range(0, 3);
			if (w > 0) begin
				out_ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// valid stays up after acceptance until the next call or an idle point
	// drops it in the same time step
	task automatic send_beat(in_beat_t b, bit no_gap = 1'b0);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// register write only with the pipe drained
	task automatic write_steps(logic [31:0] v);
		in_valid <= 1'b0;
		while (pending_count != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= 2'd0;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic in_beat_t noise_beat();
		in_beat_t b;
		logic [159:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
		b = in_beat_t'(raw[$bits(in_beat_t)-1:0]);
		return b;
	endfunction

	function automatic in_beat_t cmd_beat(cmd_t c);
		in_beat_t b;
		b = noise_beat();
		b.command = c;
		return b;
	endfunction

	function automatic in_beat_t load_beat(logic [3:0] slot, bit zero_dwell);
		in_beat_t b;
		b = cmd_beat(CMD_LOAD);
		b.step_slot = slot;
		b.step_target = ($urandom_range(0, 7) == 0) ? 16'($urandom)
			: 16'($urandom_range(0, 35999));
		b.step_direction = 2'($urandom_range(0, 3));
		b.step_dwell = zero_dwell ? 32'd0 : (($urandom_range(0, 9) == 0) ? $urandom
			: 32'($urandom_range(0, 40)));
		return b;
	endfunction

	// tick with time advancing a little, executor bits random
	function automatic in_beat_t tick_beat(ref logic [31:0] t);
		in_beat_t b;
		b = cmd_beat(CMD_TICK);
		t = t + 32'($urandom_range(0, 12));
		b.now_ms = t;
		return b;
	endfunction

	initial begin
		in_beat_t b;
		int sent;
		int sel;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: stop when stopped, tick/resume while stopped, bad commands
		send_beat(cmd_beat(CMD_STOP));
		send_beat(cmd_beat(CMD_TICK));
		send_beat(cmd_beat(CMD_RESUME));
		for (int c = 5; c < 8; c++) begin
			b = noise_beat();
			b.command = 3'(c);
			send_beat(b);
		end
		// loads: extreme target, direction three, slot above table, dwell extremes
		b = load_beat(4'd0, 1'b0); b.step_target = 16'hFFFF; b.step_dwell = '1;
		send_beat(b);
		b = load_beat(4'd1, 1'b1); b.step_target = 16'd18000; b.step_direction = DirBad;
		send_beat(b);
		b = load_beat(4'd2, 1'b1); b.step_target = 16'd0; b.step_direction = DirCw;
		send_beat(b);
		b = load_beat(4'd15, 1'b0);
		send_beat(b);
		b = load_beat(4'd9, 1'b0);
		send_beat(b);
		b = load_beat(4'd0, 1'b0); b.step_target = 16'd35999; b.step_dwell = 32'd0;
		send_beat(b);
		write_steps(32'd0);
		write_steps(32'hF);
		// start, start again, tick to dwell, resume, wrap-around dwell
		b = cmd_beat(CMD_START); b.now_ms = 32'hFFFF_FFF0; send_beat(b);
		send_beat(cmd_beat(CMD_START));
		b = cmd_beat(CMD_TICK); b.move_active = 1'b0; b.near_target = 1'b0;
		b.now_ms = 32'hFFFF_FFF8; send_beat(b);
		b = cmd_beat(CMD_RESUME); b.pause_ms = 32'hFFFF_FFFF; send_beat(b);
		b = cmd_beat(CMD_TICK); b.move_active = 1'b0; b.now_ms = 32'h10; send_beat(b);
		b = cmd_beat(CMD_TICK); b.near_target = 1'b1; b.retarget_ok = 1'b0; send_beat(b);
		b = cmd_beat(CMD_TICK); b.near_target = 1'b1; b.retarget_ok = 1'b1; send_beat(b);
		send_beat(cmd_beat(CMD_STOP));

		// random: mostly well-formed runs
		sent = 0;
		while (sent < 1850) begin
			if (sent % 400 == 0) begin
				sel = $urandom_range(0, 3);
				write_steps(sel == 0 ? 32'd1 : sel == 1 ? 32'd8 : $urandom);
			end
			for (int s = 0; s <= 8; s++) begin
				send_beat(load_beat(4'(s), 1'($urandom_range(0, 1))));
				sent++;
			end
			b = cmd_beat(CMD_START);
			b.now_ms = clock_ms;
			send_beat(b);
			sent++;
			if (sent > 900 && sent < 1000) begin
				// long hold-off at the receiver while sender keeps pushing
				stall_len = 60;
				for (int k = 0; k < 20; k++) begin
					send_beat(tick_beat(clock_ms), 1'b1);
					sent++;
				end
			end
			for (int k = 0; k < 80; k++) begin
				sel = $urandom_range(0, 99);
				if (sel < 80) b = tick_beat(clock_ms);
				else if (sel < 88) begin
					b = cmd_beat(CMD_RESUME);
					b.pause_ms = ($urandom_range(0, 3) == 0) ? $urandom
						: 32'($urandom_range(0, 20));
				end else if (sel < 94) b = load_beat(4'($urandom_range(0, 15)),
					1'($urandom_range(0, 1)));
				else if (sel < 96) b = cmd_beat(CMD_START);
				else if (sel < 98) b = noise_beat();
				else b = cmd_beat(CMD_STOP);
				send_beat(b, $urandom_range(0, 3) == 0);
				sent++;
			end
			send_beat(cmd_beat(CMD_STOP));
			sent++;
			if (sent % 5 == 0) begin
				// sender pause until the pipe drains
				in_valid <= 1'b0;
				while (pending_count != 0) @(posedge clk);
			end
		end

		in_valid <= 1'b0;
		while (pending_count != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("testbench failed");
		$finish;
	end

endmodule

// ----- motion_step_sequencer.f -----
hdl/mss_pkg.sv
hdl/mss_front.sv
hdl/mss_back.sv
hdl/motion_step_sequencer.sv
test/mss_checker.sv
test/testbench.sv
